// ===== design/assert_macros.svh =====
// assertion macros for the look-at matrix rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LAVM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define LAVM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lavm_pkg.sv =====
// shared constants and helpers for the look-at view matrix pipeline
`timescale 1ns / 1ps

package lavm_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int IN_FIELDS  = 9;
    localparam int OUT_FIELDS = 12;
    localparam int IN_BITS    = IN_FIELDS * WORD_BITS;
    localparam int OUT_BITS   = OUT_FIELDS * WORD_BITS;

    // normalizer datapath
    localparam int VEC_W      = 49;
    localparam int MAG_W      = 30;
    localparam int ALIGN_POS  = MAG_W - 1;
    localparam int LEAD_W     = 6;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int ROOT_W     = SQ_W + 3;
    localparam int ROOT_STEPS = 31;
    localparam int LEN_W      = 31;
    localparam int QUO_BITS   = FRAC_BITS + 1;
    localparam int NUM_W      = 48;
    localparam int AXIS_W     = QUO_BITS + 1;
    localparam int NORM_LAT   = 6 + ROOT_STEPS + 1 + QUO_BITS + 1;

    localparam int UNIT_ONE   = 1 << FRAC_BITS;

    // position of the highest set bit, zero for a zero word
    function automatic logic [LEAD_W-1:0] lead_pos(input logic [VEC_W-1:0] v);
        logic [LEAD_W-1:0] p;
        p = '0;
        for (int i = 0; i < VEC_W; i++)
        begin
            if (v[i])
            begin
                p = LEAD_W'(i);
            end
        end
        return p;
    endfunction

    // move the magnitude so that bit p lands on bit ALIGN_POS
    function automatic logic [MAG_W-1:0] align_mag(input logic [VEC_W-1:0] v,
                                                   input logic [LEAD_W-1:0] p);
        logic [VEC_W-1:0] s;
        if (p > LEAD_W'(ALIGN_POS))
        begin
            s = v >> (p - LEAD_W'(ALIGN_POS));
        end
        else
        begin
            s = v << (LEAD_W'(ALIGN_POS) - p);
        end
        return s[MAG_W-1:0];
    endfunction

endpackage

// ===== design/lavm_norm.sv =====
// pipelined vector normalizer: block scale, square root, three dividers
`timescale 1ns / 1ps

module lavm_norm
    import lavm_pkg::*;
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [2:0][VEC_W-1:0]        vec,
    output logic [2:0][AXIS_W-1:0]       unit
);

    typedef struct packed {
        logic [2:0][MAG_W-1:0] m;
        logic [2:0]            neg;
        logic                  zero;
    } nside_t;

    logic [2:0][VEC_W-1:0]  mag1_reg, mag2_reg, mag3_reg;
    logic [2:0]             neg1_reg, neg2_reg, neg3_reg, neg4_reg, neg5_reg;
    logic [VEC_W-1:0]       mx2_reg, mx2_next;
    logic [LEAD_W-1:0]      lead3_reg;
    logic                   zero3_reg, zero4_reg, zero5_reg;
    logic [2:0][MAG_W-1:0]  m4_reg, m5_reg;
    logic [2:0][SQ_W-1:0]   sq5_reg;

    logic [ROOT_W-1:0]      rt_rem_reg [ROOT_STEPS+1];
    logic [ROOT_W-1:0]      rt_res_reg [ROOT_STEPS+1];
    nside_t                 rt_side_reg [ROOT_STEPS+1];
    logic [ROOT_W-1:0]      rt_sum [ROOT_STEPS];
    logic [ROOT_W-1:0]      rt_bit [ROOT_STEPS];
    logic [ROOT_W-1:0]      rt_rem_next [ROOT_STEPS];
    logic [ROOT_W-1:0]      rt_res_next [ROOT_STEPS];

    logic [2:0][NUM_W-1:0]    dv_rem_reg [QUO_BITS+1];
    logic [2:0][QUO_BITS-1:0] dv_q_reg [QUO_BITS+1];
    logic [LEN_W-1:0]         dv_len_reg [QUO_BITS+1];
    nside_t                   dv_side_reg [QUO_BITS+1];
    logic [NUM_W-1:0]         dv_dsr [QUO_BITS];
    logic [2:0][NUM_W-1:0]    dv_rem_next [QUO_BITS];
    logic [2:0][QUO_BITS-1:0] dv_q_next [QUO_BITS];

    logic [LEN_W-1:0]         root_len;
    logic [2:0][AXIS_W-1:0]   unit_reg;

    always_comb
    begin
        mx2_next = mag1_reg[0];
        if (mag1_reg[1] > mx2_next)
        begin
            mx2_next = mag1_reg[1];
        end
        if (mag1_reg[2] > mx2_next)
        begin
            mx2_next = mag1_reg[2];
        end
    end

    // one result bit of the square root per stage
    always_comb
    begin
        for (int k = 0; k < ROOT_STEPS; k++)
        begin
            rt_bit[k] = ROOT_W'(1) << (2 * (ROOT_STEPS - 1 - k));
            rt_sum[k] = rt_res_reg[k] + rt_bit[k];
            if (rt_rem_reg[k] >= rt_sum[k])
            begin
                rt_rem_next[k] = rt_rem_reg[k] - rt_sum[k];
                rt_res_next[k] = (rt_res_reg[k] >> 1) + rt_bit[k];
            end
            else
            begin
                rt_rem_next[k] = rt_rem_reg[k];
                rt_res_next[k] = rt_res_reg[k] >> 1;
            end
        end
    end

    assign root_len = rt_res_reg[ROOT_STEPS][LEN_W-1:0];

    // restoring division, one quotient bit per stage in each lane
    always_comb
    begin
        for (int j = 0; j < QUO_BITS; j++)
        begin
            dv_dsr[j] = NUM_W'(dv_len_reg[j]) << (QUO_BITS - 1 - j);
            for (int i = 0; i < 3; i++)
            begin
                if (dv_rem_reg[j][i] >= dv_dsr[j])
                begin
                    dv_rem_next[j][i] = dv_rem_reg[j][i] - dv_dsr[j];
                    dv_q_next[j][i]   = dv_q_reg[j][i] | (QUO_BITS'(1) << (QUO_BITS - 1 - j));
                end
                else
                begin
                    dv_rem_next[j][i] = dv_rem_reg[j][i];
                    dv_q_next[j][i]   = dv_q_reg[j][i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg1_reg[i] <= vec[i][VEC_W-1];
                mag1_reg[i] <= vec[i][VEC_W-1] ? -vec[i] : vec[i];
            end
            mx2_reg   <= mx2_next;
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;

            lead3_reg <= lead_pos(mx2_reg);
            zero3_reg <= (mx2_reg == '0);
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;

            for (int i = 0; i < 3; i++)
            begin
                m4_reg[i] <= align_mag(mag3_reg[i], lead3_reg);
            end
            zero4_reg <= zero3_reg;
            neg4_reg  <= neg3_reg;

            for (int i = 0; i < 3; i++)
            begin
                sq5_reg[i] <= m4_reg[i] * m4_reg[i];
            end
            m5_reg    <= m4_reg;
            zero5_reg <= zero4_reg;
            neg5_reg  <= neg4_reg;

            rt_rem_reg[0]  <= ROOT_W'(sq5_reg[0]) + ROOT_W'(sq5_reg[1]) + ROOT_W'(sq5_reg[2]);
            rt_res_reg[0]  <= '0;
            rt_side_reg[0] <= {m5_reg, neg5_reg, zero5_reg};
            for (int k = 0; k < ROOT_STEPS; k++)
            begin
                rt_rem_reg[k+1]  <= rt_rem_next[k];
                rt_res_reg[k+1]  <= rt_res_next[k];
                rt_side_reg[k+1] <= rt_side_reg[k];
            end

            // numerator carries half the length for round to nearest
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= NUM_W'({rt_side_reg[ROOT_STEPS].m[i], {FRAC_BITS{1'b0}}})
                                    + NUM_W'(root_len >> 1);
            end
            dv_q_reg[0]    <= '0;
            dv_len_reg[0]  <= root_len;
            dv_side_reg[0] <= rt_side_reg[ROOT_STEPS];
            for (int j = 0; j < QUO_BITS; j++)
            begin
                dv_rem_reg[j+1]  <= dv_rem_next[j];
                dv_q_reg[j+1]    <= dv_q_next[j];
                dv_len_reg[j+1]  <= dv_len_reg[j];
                dv_side_reg[j+1] <= dv_side_reg[j];
            end

            for (int i = 0; i < 3; i++)
            begin
                if (dv_side_reg[QUO_BITS].zero)
                begin
                    unit_reg[i] <= '0;
                end
                else if (dv_side_reg[QUO_BITS].neg[i])
                begin
                    unit_reg[i] <= -{1'b0, dv_q_reg[QUO_BITS][i]};
                end
                else
                begin
                    unit_reg[i] <= {1'b0, dv_q_reg[QUO_BITS][i]};
                end
            end
        end
    end

    assign unit = unit_reg;

endmodule

// ===== design/look_at_view_matrix_core.sv =====
// Look-at view matrix core: one camera setup in, three matrix rows out, one item per cycle.
// A new item can be accepted every cycle while the output is not stalled. The depth comes
// from two normalizers in series (forward, then right axis), each a 31-stage square root
// followed by a 17-stage divider, plus the cross product, dot product and saturation stages.
// The whole pipeline freezes while the output register holds an item that has not been taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module look_at_view_matrix_core
    import lavm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z (32 bits each)
    input  logic [IN_BITS-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // right_x, right_y, right_z, right_shift, vert_x, vert_y, vert_z, vert_shift,
    // back_x, back_y, back_z, back_shift (32 bits each)
    output logic [OUT_BITS-1:0] m_tdata
);

    localparam int UPM_W   = WORD_BITS + 1;
    localparam int UPS_W   = MAG_W + 1;
    localparam int XP_W    = AXIS_W + UPS_W;
    localparam int UPS_DLY = NORM_LAT - 2;
    localparam int F_DLY   = NORM_LAT + 2;
    localparam int EYE_DLY = 2 * NORM_LAT + 3;
    localparam int VLD_N   = 2 * NORM_LAT + 7;
    localparam int EH_W    = WORD_BITS - FRAC_BITS;
    localparam int HP_W    = AXIS_W + EH_W;
    localparam int LP_W    = AXIS_W + FRAC_BITS + 1;
    localparam int PR_W    = 2 * AXIS_W;
    localparam int U_W     = AXIS_W + 2;
    localparam int UHP_W   = U_W + EH_W;
    localparam int ULP_W   = U_W + FRAC_BITS + 1;
    localparam int DOT_W   = 48;

    localparam logic signed [DOT_W-1:0] SAT_HI =
        {{(DOT_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [DOT_W-1:0] SAT_LO =
        {{(DOT_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [DOT_W-1:0] HALF_LSB = DOT_W'(1) << (FRAC_BITS - 1);

    function automatic logic [WORD_BITS-1:0] sat_word(input logic signed [DOT_W-1:0] v);
        logic [WORD_BITS-1:0] w;
        if (v > SAT_HI)
        begin
            w = SAT_HI[WORD_BITS-1:0];
        end
        else if (v < SAT_LO)
        begin
            w = SAT_LO[WORD_BITS-1:0];
        end
        else
        begin
            w = v[WORD_BITS-1:0];
        end
        return w;
    endfunction

    // shift right by the fraction width, ties toward plus infinity
    function automatic logic signed [DOT_W-1:0] rnd_shift(input logic signed [DOT_W-1:0] x);
        logic signed [DOT_W-1:0] t;
        t = x + HALF_LSB;
        return t >>> FRAC_BITS;
    endfunction

    // integer part products plus rounded fraction part products
    function automatic logic signed [DOT_W-1:0] dot_fix(
        input logic signed [DOT_W-1:0] h0, input logic signed [DOT_W-1:0] h1,
        input logic signed [DOT_W-1:0] h2, input logic signed [DOT_W-1:0] l0,
        input logic signed [DOT_W-1:0] l1, input logic signed [DOT_W-1:0] l2);
        logic signed [DOT_W-1:0] hs;
        logic signed [DOT_W-1:0] ls;
        hs = h0 + h1 + h2;
        ls = l0 + l1 + l2;
        return hs + rnd_shift(ls);
    endfunction

    logic                    en;
    logic                    vld_reg [VLD_N];
    logic                    out_valid_reg;
    logic [OUT_BITS-1:0]     out_data_reg, out_data_next;

    logic [2:0][WORD_BITS-1:0] eye_in, target_in, up_in;
    logic [2:0][VEC_W-1:0]     d1_reg;
    logic [2:0][UPM_W-1:0]     um1_reg, um2_reg, um3_reg;
    logic [2:0]                un1_reg, un2_reg, un3_reg;
    logic [UPM_W-1:0]          umx2_reg, umx2_next;
    logic [LEAD_W-1:0]         ulead3_reg;
    logic [2:0][UPS_W-1:0]     ups_next;
    logic [2:0][UPS_W-1:0]     ups_dly_reg [UPS_DLY];
    logic [2:0][WORD_BITS-1:0] eye_dly_reg [EYE_DLY];
    logic [2:0][AXIS_W-1:0]    f_dly_reg [F_DLY];
    logic [2:0][AXIS_W-1:0]    f_unit, r_unit;

    logic signed [XP_W-1:0]    xp_reg [6];
    logic [2:0][VEC_W-1:0]     c_reg;

    logic [2:0][WORD_BITS-1:0] eye_w;
    logic signed [PR_W-1:0]    ur_a_reg [6];
    logic signed [HP_W-1:0]    rh_a_reg [3], fh_a_reg [3];
    logic signed [LP_W-1:0]    rl_a_reg [3], fl_a_reg [3];
    logic [2:0][AXIS_W-1:0]    r_a_reg, f_a_reg, r_b_reg, f_b_reg, r_c_reg, f_c_reg;
    logic [2:0][AXIS_W-1:0]    r_d_reg, f_d_reg;
    logic [2:0][WORD_BITS-1:0] eye_a_reg, eye_b_reg;
    logic signed [U_W-1:0]     u_b_reg [3], u_c_reg [3], u_d_reg [3];
    logic signed [DOT_W-1:0]   u_rnd [3];
    logic signed [DOT_W-1:0]   dot_r_b_reg, dot_f_b_reg, dot_u_d_reg;
    logic signed [UHP_W-1:0]   uh_c_reg [3];
    logic signed [ULP_W-1:0]   ul_c_reg [3];
    logic [WORD_BITS-1:0]      rs_c_reg, bs_c_reg, rs_d_reg, bs_d_reg;
    logic [WORD_BITS-1:0]      words [OUT_FIELDS];

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye_in[i]    = s_tdata[WORD_BITS*i +: WORD_BITS];
            target_in[i] = s_tdata[WORD_BITS*(3+i) +: WORD_BITS];
            up_in[i]     = s_tdata[WORD_BITS*(6+i) +: WORD_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < VLD_N; n++)
            begin
                vld_reg[n] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int n = 1; n < VLD_N; n++)
            begin
                vld_reg[n] <= vld_reg[n-1];
            end
            out_valid_reg <= vld_reg[VLD_N-1];
        end
    end

    always_comb
    begin
        umx2_next = um1_reg[0];
        if (um1_reg[1] > umx2_next)
        begin
            umx2_next = um1_reg[1];
        end
        if (um1_reg[2] > umx2_next)
        begin
            umx2_next = um1_reg[2];
        end
        for (int i = 0; i < 3; i++)
        begin
            if (un3_reg[i])
            begin
                ups_next[i] = -{1'b0, align_mag(VEC_W'(um3_reg[i]), ulead3_reg)};
            end
            else
            begin
                ups_next[i] = {1'b0, align_mag(VEC_W'(um3_reg[i]), ulead3_reg)};
            end
        end
    end

    // forward direction
    lavm_norm u_norm_fwd (
        .clk  (clk),
        .en   (en),
        .vec  (d1_reg),
        .unit (f_unit)
    );

    // right axis
    lavm_norm u_norm_right (
        .clk  (clk),
        .en   (en),
        .vec  (c_reg),
        .unit (r_unit)
    );

    assign eye_w = eye_dly_reg[EYE_DLY-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_rnd[i] = '0;
        end
        u_rnd[0] = rnd_shift(DOT_W'(ur_a_reg[0]) - DOT_W'(ur_a_reg[1]));
        u_rnd[1] = rnd_shift(DOT_W'(ur_a_reg[2]) - DOT_W'(ur_a_reg[3]));
        u_rnd[2] = rnd_shift(DOT_W'(ur_a_reg[4]) - DOT_W'(ur_a_reg[5]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // difference and up magnitudes
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i]  <= VEC_W'($signed(target_in[i])) - VEC_W'($signed(eye_in[i]));
                un1_reg[i] <= up_in[i][WORD_BITS-1];
                um1_reg[i] <= up_in[i][WORD_BITS-1] ? -{up_in[i][WORD_BITS-1], up_in[i]}
                                                   : {1'b0, up_in[i]};
            end
            umx2_reg   <= umx2_next;
            um2_reg    <= um1_reg;
            un2_reg    <= un1_reg;
            ulead3_reg <= lead_pos(VEC_W'(umx2_reg));
            um3_reg    <= um2_reg;
            un3_reg    <= un2_reg;

            ups_dly_reg[0] <= ups_next;
            for (int n = 1; n < UPS_DLY; n++)
            begin
                ups_dly_reg[n] <= ups_dly_reg[n-1];
            end
            eye_dly_reg[0] <= eye_in;
            for (int n = 1; n < EYE_DLY; n++)
            begin
                eye_dly_reg[n] <= eye_dly_reg[n-1];
            end
            f_dly_reg[0] <= f_unit;
            for (int n = 1; n < F_DLY; n++)
            begin
                f_dly_reg[n] <= f_dly_reg[n-1];
            end

            // cross of forward and scaled up
            xp_reg[0] <= $signed(f_unit[1]) * $signed(ups_dly_reg[UPS_DLY-1][2]);
            xp_reg[1] <= $signed(f_unit[2]) * $signed(ups_dly_reg[UPS_DLY-1][1]);
            xp_reg[2] <= $signed(f_unit[2]) * $signed(ups_dly_reg[UPS_DLY-1][0]);
            xp_reg[3] <= $signed(f_unit[0]) * $signed(ups_dly_reg[UPS_DLY-1][2]);
            xp_reg[4] <= $signed(f_unit[0]) * $signed(ups_dly_reg[UPS_DLY-1][1]);
            xp_reg[5] <= $signed(f_unit[1]) * $signed(ups_dly_reg[UPS_DLY-1][0]);
            c_reg[0]  <= xp_reg[0] - xp_reg[1];
            c_reg[1]  <= xp_reg[2] - xp_reg[3];
            c_reg[2]  <= xp_reg[4] - xp_reg[5];

            // products for the true up axis and the eye offsets
            ur_a_reg[0] <= $signed(r_unit[1]) * $signed(f_dly_reg[F_DLY-1][2]);
            ur_a_reg[1] <= $signed(r_unit[2]) * $signed(f_dly_reg[F_DLY-1][1]);
            ur_a_reg[2] <= $signed(r_unit[2]) * $signed(f_dly_reg[F_DLY-1][0]);
            ur_a_reg[3] <= $signed(r_unit[0]) * $signed(f_dly_reg[F_DLY-1][2]);
            ur_a_reg[4] <= $signed(r_unit[0]) * $signed(f_dly_reg[F_DLY-1][1]);
            ur_a_reg[5] <= $signed(r_unit[1]) * $signed(f_dly_reg[F_DLY-1][0]);
            for (int i = 0; i < 3; i++)
            begin
                rh_a_reg[i] <= $signed(r_unit[i]) * $signed(eye_w[i][WORD_BITS-1:FRAC_BITS]);
                rl_a_reg[i] <= $signed(r_unit[i]) * $signed({1'b0, eye_w[i][FRAC_BITS-1:0]});
                fh_a_reg[i] <= $signed(f_dly_reg[F_DLY-1][i])
                               * $signed(eye_w[i][WORD_BITS-1:FRAC_BITS]);
                fl_a_reg[i] <= $signed(f_dly_reg[F_DLY-1][i])
                               * $signed({1'b0, eye_w[i][FRAC_BITS-1:0]});
            end
            r_a_reg   <= r_unit;
            f_a_reg   <= f_dly_reg[F_DLY-1];
            eye_a_reg <= eye_w;

            for (int i = 0; i < 3; i++)
            begin
                u_b_reg[i] <= u_rnd[i][U_W-1:0];
            end
            dot_r_b_reg <= dot_fix(DOT_W'(rh_a_reg[0]), DOT_W'(rh_a_reg[1]),
                                   DOT_W'(rh_a_reg[2]), DOT_W'(rl_a_reg[0]),
                                   DOT_W'(rl_a_reg[1]), DOT_W'(rl_a_reg[2]));
            dot_f_b_reg <= dot_fix(DOT_W'(fh_a_reg[0]), DOT_W'(fh_a_reg[1]),
                                   DOT_W'(fh_a_reg[2]), DOT_W'(fl_a_reg[0]),
                                   DOT_W'(fl_a_reg[1]), DOT_W'(fl_a_reg[2]));
            r_b_reg   <= r_a_reg;
            f_b_reg   <= f_a_reg;
            eye_b_reg <= eye_a_reg;

            for (int i = 0; i < 3; i++)
            begin
                uh_c_reg[i] <= u_b_reg[i] * $signed(eye_b_reg[i][WORD_BITS-1:FRAC_BITS]);
                ul_c_reg[i] <= u_b_reg[i] * $signed({1'b0, eye_b_reg[i][FRAC_BITS-1:0]});
                u_c_reg[i]  <= u_b_reg[i];
            end
            rs_c_reg <= sat_word(-dot_r_b_reg);
            bs_c_reg <= sat_word(dot_f_b_reg);
            r_c_reg  <= r_b_reg;
            f_c_reg  <= f_b_reg;

            dot_u_d_reg <= dot_fix(DOT_W'(uh_c_reg[0]), DOT_W'(uh_c_reg[1]),
                                   DOT_W'(uh_c_reg[2]), DOT_W'(ul_c_reg[0]),
                                   DOT_W'(ul_c_reg[1]), DOT_W'(ul_c_reg[2]));
            for (int i = 0; i < 3; i++)
            begin
                u_d_reg[i] <= u_c_reg[i];
            end
            rs_d_reg <= rs_c_reg;
            bs_d_reg <= bs_c_reg;
            r_d_reg  <= r_c_reg;
            f_d_reg  <= f_c_reg;

            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            words[i]     = sat_word(DOT_W'($signed(r_d_reg[i])));
            words[4 + i] = sat_word(DOT_W'(u_d_reg[i]));
            words[8 + i] = sat_word(-DOT_W'($signed(f_d_reg[i])));
        end
        words[3]  = rs_d_reg;
        words[7]  = sat_word(-dot_u_d_reg);
        words[11] = bs_d_reg;
        for (int k = 0; k < OUT_FIELDS; k++)
        begin
            out_data_next[WORD_BITS*k +: WORD_BITS] = words[k];
        end
    end

    // the back_x word, the negated normalized forward x, never exceeds one in magnitude
    `LAVM_ASSERT_IMP(a_back_bound, m_tvalid, ($signed(m_tdata[WORD_BITS*8 +: WORD_BITS]) <= UNIT_ONE) && ($signed(m_tdata[WORD_BITS*8 +: WORD_BITS]) >= -UNIT_ONE), "back_x beyond unit length")
    // no forward direction means no right axis
    `LAVM_ASSERT_IMP(a_zero_fwd, m_tvalid && (m_tdata[WORD_BITS*8 +: WORD_BITS] == '0) && (m_tdata[WORD_BITS*9 +: WORD_BITS] == '0) && (m_tdata[WORD_BITS*10 +: WORD_BITS] == '0), (m_tdata[WORD_BITS*0 +: WORD_BITS] == '0) && (m_tdata[WORD_BITS*1 +: WORD_BITS] == '0) && (m_tdata[WORD_BITS*2 +: WORD_BITS] == '0), "right axis set with zero forward")
    // no right axis means no true up axis and no offsets for either
    `LAVM_ASSERT_IMP(a_zero_right, m_tvalid && (m_tdata[WORD_BITS*0 +: WORD_BITS] == '0) && (m_tdata[WORD_BITS*1 +: WORD_BITS] == '0) && (m_tdata[WORD_BITS*2 +: WORD_BITS] == '0), (m_tdata[WORD_BITS*3 +: WORD_BITS] == '0) && (m_tdata[WORD_BITS*4 +: WORD_BITS] == '0) && (m_tdata[WORD_BITS*5 +: WORD_BITS] == '0) && (m_tdata[WORD_BITS*6 +: WORD_BITS] == '0) && (m_tdata[WORD_BITS*7 +: WORD_BITS] == '0), "vert row set with zero right axis")

endmodule
